@@ hw/rtl/multi_button_press_classifier_defines.svh @@
// Assertion macros shared by the verification code of the button press classifier.
// Used by mbpc_checker.sv; no other dependencies.
`ifndef MULTI_BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define MULTI_BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MBPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MBPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset
`define MBPC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mbpc_pkg.sv @@
// Package for the multi-button press classifier: payload and config types,
// event codes, register indexes and controller states. No dependencies.
`default_nettype none

package mbpc_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int BTN_W       = 3;   // width of button_index

    // Event kinds
    localparam logic [2:0] EV_PRESS  = 3'd0;
    localparam logic [2:0] EV_SHORT  = 3'd1;
    localparam logic [2:0] EV_MEDIUM = 3'd2;
    localparam logic [2:0] EV_LONG   = 3'd3;
    localparam logic [2:0] EV_CANCEL = 3'd4;
    localparam logic [2:0] EV_REPEAT = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_POLL_INTERVAL = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE      = 3'd1;
    localparam logic [2:0] CFG_SHORT_MAX     = 3'd2;
    localparam logic [2:0] CFG_MEDIUM_MAX    = 3'd3;
    localparam logic [2:0] CFG_RELEASE_MASK  = 3'd4;
    localparam logic [2:0] CFG_REPEAT_MASK   = 3'd5;
    localparam logic [2:0] CFG_REPEAT_IVL    = 3'd6;
    localparam logic [2:0] CFG_INJECT_HOLD   = 3'd7;

    // Configuration reset values
    localparam logic [15:0]            RST_POLL_INTERVAL = 16'd10;
    localparam logic [7:0]             RST_DEBOUNCE      = 8'd20;
    localparam logic [15:0]            RST_SHORT_MAX     = 16'd500;
    localparam logic [15:0]            RST_MEDIUM_MAX    = 16'd1500;
    localparam logic [NUM_BUTTONS-1:0] RST_RELEASE_MASK  = NUM_BUTTONS'(25);
    localparam logic [NUM_BUTTONS-1:0] RST_REPEAT_MASK   = '0;
    localparam logic [15:0]            RST_REPEAT_IVL    = 16'd120;
    localparam logic [15:0]            RST_INJECT_HOLD   = 16'd250;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_levels;
        logic [31:0]            time_ms;
        logic [NUM_BUTTONS-1:0] active_match_mask;
    } t_in;

    typedef struct packed {
        logic [BTN_W-1:0] button_index;
        logic [2:0]       event_kind;
        logic [15:0]      hold_time_ms;
        logic [31:0]      press_len_ms;
        logic             last_event;
    } t_out;

    typedef struct packed {
        logic [15:0]            poll_interval_ms;
        logic [7:0]             debounce_ms;
        logic [15:0]            short_max_ms;
        logic [15:0]            medium_max_ms;
        logic [NUM_BUTTONS-1:0] release_class_mask;
        logic [NUM_BUTTONS-1:0] repeat_mask;
        logic [15:0]            repeat_interval_ms;
        logic [15:0]            inject_hold_ms;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic             load;   // capture the incoming request
        logic             poll;   // poll interval check
        logic             deb;    // debounce step for button idx
        logic             rep;    // repeat step for button idx
        logic             flush;  // send the held event as the last one
        logic [BTN_W-1:0] idx;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic too_soon;    // request came before the poll interval passed
        logic can_step;    // an event produced now has room to go
        logic pend_valid;  // an event waits to be sent
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POLL,
        S_DEB,
        S_REP,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ hw/rtl/multi_button_press_classifier.sv @@
// Top level of the multi-button press classifier (debounce, release classes,
// hold repeat). Depends on mbpc_pkg, mbpc_cfg, mbpc_ctrl and mbpc_dp.
// A polled request walks capture, poll check, six debounce and six repeat steps and
// flush; an early one ends after the poll check. No new request is taken until the walk ends.
// Results leave through the output register; an output stall holds the walk.
// Reset (synchronous, active low) restores config defaults and clears control, per-button and valid state.
`default_nettype none

module multi_button_press_classifier
    import mbpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    mbpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mbpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mbpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mbpc_cfg.sv @@
// Configuration register file of the press classifier.
// Depends on mbpc_pkg.
`default_nettype none

module mbpc_cfg
    import mbpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    // Register writes, masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval_ms   <= RST_POLL_INTERVAL;
            r_cfg.debounce_ms        <= RST_DEBOUNCE;
            r_cfg.short_max_ms       <= RST_SHORT_MAX;
            r_cfg.medium_max_ms      <= RST_MEDIUM_MAX;
            r_cfg.release_class_mask <= RST_RELEASE_MASK;
            r_cfg.repeat_mask        <= RST_REPEAT_MASK;
            r_cfg.repeat_interval_ms <= RST_REPEAT_IVL;
            r_cfg.inject_hold_ms     <= RST_INJECT_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLL_INTERVAL: r_cfg.poll_interval_ms   <= i_cfg_data;
                CFG_DEBOUNCE:      r_cfg.debounce_ms        <= i_cfg_data[7:0];
                CFG_SHORT_MAX:     r_cfg.short_max_ms       <= i_cfg_data;
                CFG_MEDIUM_MAX:    r_cfg.medium_max_ms      <= i_cfg_data;
                CFG_RELEASE_MASK:  r_cfg.release_class_mask <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_REPEAT_MASK:   r_cfg.repeat_mask        <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_REPEAT_IVL:    r_cfg.repeat_interval_ms <= i_cfg_data;
                CFG_INJECT_HOLD:   r_cfg.inject_hold_ms     <= i_cfg_data;
                default:           r_cfg.inject_hold_ms     <= r_cfg.inject_hold_ms;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/mbpc_ctrl.sv @@
// Controller of the press classifier: sequences poll check, debounce walk,
// repeat walk and final flush. Depends on mbpc_pkg.
`default_nettype none

module mbpc_ctrl
    import mbpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [BTN_W-1:0] LAST_IDX = BTN_W'(NUM_BUTTONS - 1);

    t_state           r_state, n_state;
    logic [BTN_W-1:0] r_idx, n_idx;

    // State and button counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_POLL;
                end
            end
            S_POLL: begin
                o_cmd.poll = 1'b1;
                n_idx      = '0;
                n_state    = i_sts.too_soon ? S_IDLE : S_DEB;
            end
            S_DEB: begin
                if (i_sts.can_step) begin
                    o_cmd.deb = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_REP;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_REP: begin
                if (i_sts.can_step) begin
                    o_cmd.rep = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.can_step) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/mbpc_dp.sv @@
// Datapath of the press classifier: sample capture, per-button state,
// event build, held event and output register. Depends on mbpc_pkg.
`default_nettype none

module mbpc_dp
    import mbpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    // Captured request
    logic [NUM_BUTTONS-1:0] r_raw;
    logic [31:0]            r_now;
    logic [NUM_BUTTONS-1:0] r_active;

    // Per-button state
    logic [31:0]            r_last_poll;
    logic [NUM_BUTTONS-1:0] r_raw_seen;
    logic [NUM_BUTTONS-1:0] r_stable;
    logic [31:0]            r_change_time [NUM_BUTTONS];
    logic [31:0]            r_press_start [NUM_BUTTONS];
    logic [31:0]            r_last_emit   [NUM_BUTTONS];

    // Held event and output register
    logic r_pend_valid;
    t_out r_pend;
    logic r_out_valid;
    t_out r_out;

    logic [BTN_W-1:0] b;
    logic             lvl;
    logic [31:0]      ct_eff;
    logic [31:0]      deb_diff;
    logic             held_ok;
    logic             do_change;
    logic [31:0]      dur;
    logic [31:0]      rep_diff;
    logic             rep_hit;
    logic             ev_valid;
    t_out             ev;
    logic             le_wr;
    logic [31:0]      le_val;
    logic             out_free;
    logic             push;
    t_out             push_ev;

    assign b        = i_cmd.idx;
    assign out_free = !r_out_valid || !i_out_stall;
    assign push     = (ev_valid && r_pend_valid) || i_cmd.flush;

    // Debounce and repeat decisions for the selected button
    always_comb begin
        lvl       = r_raw[b];
        ct_eff    = (lvl != r_raw_seen[b]) ? r_now : r_change_time[b];
        deb_diff  = r_now - ct_eff;
        held_ok   = (i_cfg.debounce_ms == '0) || (deb_diff >= {24'd0, i_cfg.debounce_ms});
        do_change = (lvl != r_stable[b]) && held_ok;
        dur       = (r_press_start[b] == '0) ? '0 : (r_now - r_press_start[b]);
        rep_diff  = r_now - r_last_emit[b];
        rep_hit   = r_stable[b] && i_cfg.repeat_mask[b]
                    && (rep_diff >= {16'd0, i_cfg.repeat_interval_ms});
    end

    // Event build
    always_comb begin
        ev_valid        = 1'b0;
        le_wr           = 1'b0;
        le_val          = r_now;
        ev.button_index = b;
        ev.event_kind   = EV_PRESS;
        ev.hold_time_ms = i_cfg.inject_hold_ms;
        ev.press_len_ms = '0;
        ev.last_event   = 1'b0;
        if (i_cmd.deb && do_change) begin
            if (lvl) begin
                if (!i_cfg.release_class_mask[b]) begin
                    ev_valid = 1'b1;
                    le_wr    = 1'b1;
                end
            end else if (i_cfg.release_class_mask[b]) begin
                ev_valid        = 1'b1;
                le_wr           = 1'b1;
                ev.press_len_ms = dur;
                priority if (dur < {16'd0, i_cfg.short_max_ms}) begin
                    ev.event_kind = EV_SHORT;
                end else if (dur < {16'd0, i_cfg.medium_max_ms}) begin
                    ev.event_kind = EV_MEDIUM;
                end else begin
                    ev.event_kind = EV_LONG;
                end
            end else if (r_active[b]) begin
                ev_valid        = 1'b1;
                le_wr           = 1'b1;
                le_val          = '0;
                ev.event_kind   = EV_CANCEL;
                ev.hold_time_ms = '0;
            end
        end else if (i_cmd.rep && rep_hit) begin
            ev_valid      = 1'b1;
            le_wr         = 1'b1;
            ev.event_kind = EV_REPEAT;
        end
    end

    // Next output register content: the held event, marked last on flush
    always_comb begin
        push_ev            = r_pend;
        push_ev.last_event = i_cmd.flush;
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw    <= i_in_data.raw_levels;
            r_now    <= i_in_data.time_ms;
            r_active <= i_in_data.active_match_mask;
        end
    end

    // Poll time and per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_poll <= '0;
            r_raw_seen  <= '0;
            r_stable    <= '0;
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                r_change_time[k] <= '0;
                r_press_start[k] <= '0;
                r_last_emit[k]   <= '0;
            end
        end else begin
            if (i_cmd.poll && !o_sts.too_soon) begin
                r_last_poll <= r_now;
            end
            if (i_cmd.deb) begin
                r_raw_seen[b]    <= lvl;
                r_change_time[b] <= ct_eff;
                if (do_change) begin
                    r_stable[b]      <= lvl;
                    r_press_start[b] <= lvl ? r_now : '0;
                end
            end
            if (le_wr) begin
                r_last_emit[b] <= le_val;
            end
        end
    end

    // Held event and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (ev_valid) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held event and output register payload
    always_ff @(posedge i_clk) begin
        if (ev_valid) begin
            r_pend <= ev;
        end
        if (push) begin
            r_out <= push_ev;
        end
    end

    assign o_sts.too_soon   = (r_now - r_last_poll) < {16'd0, i_cfg.poll_interval_ms};
    assign o_sts.can_step   = !r_pend_valid || out_free;
    assign o_sts.pend_valid = r_pend_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/mbpc_checker.sv @@
// Port-level checks for the press classifier, bound to the top level.
// Depends on mbpc_pkg and multi_button_press_classifier_defines.svh.
`default_nettype none

`include "multi_button_press_classifier_defines.svh"

module mbpc_checker
    import mbpc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data,
    input wire logic i_cfg_we
);

    logic in_acc;
    logic out_hold;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_hold = o_out_valid && i_out_stall;

    // A stalled result stays put
    `MBPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_out_data), "stalled result changed")

    // Reset empties the output and opens the input side
    `MBPC_ASSERT_NXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "reset did not clear")

    // An accepted request keeps the block busy for at least the poll check
    `MBPC_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, in_acc, o_in_stall, "no busy after request")

    // While a non-final result is shown, more of the same request is still in work
    `MBPC_ASSERT_IMP(a_nonlast_busy, i_clk, i_rst_n, o_out_valid && !o_out_data.last_event, o_in_stall, "idle with a non-final result out")

    // Config writes must land only while nothing is in flight; the block does not enforce this
    `MBPC_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, !o_in_stall && !o_out_valid, "config write while busy")

endmodule

bind multi_button_press_classifier mbpc_checker u_mbpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we)
);

`default_nettype wire

@@ tb/multi_button_press_classifier_tb.sv @@
// Self-checking testbench for the multi-button press classifier.
// Needs mbpc_pkg and the classifier RTL; a class inside the top predicts and checks events.

module multi_button_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbpc_pkg::*;

    localparam int MAX_EVENTS    = 12;     // events one sample can produce
    localparam int NUM_REGS      = 8;
    localparam int SETTLE_CYCLES = 40;     // covers the walk of a silent request
    localparam int PHASE_SAMPLES = 78;
    localparam int LIMIT_NS      = 1_000_000;

    // Predicts the events of each accepted sample and checks them in order
    class press_event_tracker;
        t_cfg                   cfg;
        logic [31:0]            last_poll;
        logic [NUM_BUTTONS-1:0] raw_seen;
        logic [NUM_BUTTONS-1:0] stable;
        logic [31:0]            change_at [NUM_BUTTONS];
        logic [31:0]            start_at  [NUM_BUTTONS];
        logic [31:0]            emit_at   [NUM_BUTTONS];
        t_out                   sample_events [$];
        t_out                   pending_events [$];
        int                     n_samples;
        int                     n_skipped;
        int                     n_checked;
        int                     n_errors;
        int                     kind_seen [8];

        function new();
            cfg.poll_interval_ms   = RST_POLL_INTERVAL;
            cfg.debounce_ms        = RST_DEBOUNCE;
            cfg.short_max_ms       = RST_SHORT_MAX;
            cfg.medium_max_ms      = RST_MEDIUM_MAX;
            cfg.release_class_mask = RST_RELEASE_MASK;
            cfg.repeat_mask        = RST_REPEAT_MASK;
            cfg.repeat_interval_ms = RST_REPEAT_IVL;
            cfg.inject_hold_ms     = RST_INJECT_HOLD;
            last_poll = '0;
            raw_seen  = '0;
            stable    = '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                change_at[b] = '0;
                start_at[b]  = '0;
                emit_at[b]   = '0;
            end
        endfunction

        // Register write; bits above a register's width are dropped
        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_POLL_INTERVAL: cfg.poll_interval_ms   = data;
                CFG_DEBOUNCE:      cfg.debounce_ms        = data[7:0];
                CFG_SHORT_MAX:     cfg.short_max_ms       = data;
                CFG_MEDIUM_MAX:    cfg.medium_max_ms      = data;
                CFG_RELEASE_MASK:  cfg.release_class_mask = data[NUM_BUTTONS-1:0];
                CFG_REPEAT_MASK:   cfg.repeat_mask        = data[NUM_BUTTONS-1:0];
                CFG_REPEAT_IVL:    cfg.repeat_interval_ms = data;
                CFG_INJECT_HOLD:   cfg.inject_hold_ms     = data;
                default: ;
            endcase
        endfunction

        // Events past the per-sample cap are dropped, their state updates are not
        function void log_event(int b, logic [2:0] kind, logic [15:0] hold, logic [31:0] dur);
            t_out ev;
            if (sample_events.size() >= MAX_EVENTS) return;
            ev.button_index = BTN_W'(b);
            ev.event_kind   = kind;
            ev.hold_time_ms = hold;
            ev.press_len_ms = dur;
            ev.last_event   = 1'b0;
            sample_events.push_back(ev);
        endfunction

        function void note_sample(t_in req);
            logic [31:0] now;
            logic [31:0] elapsed;
            logic [31:0] dur;
            logic [2:0]  kind;
            logic        lvl;
            t_out        ev;
            now = req.time_ms;
            elapsed = now - last_poll;
            if (elapsed < {16'b0, cfg.poll_interval_ms}) begin
                n_skipped++;
                return;
            end
            n_samples++;
            last_poll = now;
            sample_events.delete();

            // debounce walk, button 0 first
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                lvl = req.raw_levels[b];
                if (lvl != raw_seen[b]) begin
                    raw_seen[b]  = lvl;
                    change_at[b] = now;
                end
                if (lvl == stable[b]) continue;
                elapsed = now - change_at[b];
                if (cfg.debounce_ms != 0 && elapsed < {24'b0, cfg.debounce_ms}) continue;
                stable[b] = lvl;
                if (lvl) begin
                    start_at[b] = now;
                    if (!cfg.release_class_mask[b]) begin
                        log_event(b, EV_PRESS, cfg.inject_hold_ms, '0);
                        emit_at[b] = now;
                    end
                end else begin
                    // a start stored as zero reads as no start
                    dur = (start_at[b] == 0) ? '0 : now - start_at[b];
                    start_at[b] = '0;
                    if (cfg.release_class_mask[b]) begin
                        if (dur < {16'b0, cfg.short_max_ms})
                            kind = EV_SHORT;
                        else if (dur < {16'b0, cfg.medium_max_ms})
                            kind = EV_MEDIUM;
                        else
                            kind = EV_LONG;
                        log_event(b, kind, cfg.inject_hold_ms, dur);
                        emit_at[b] = now;
                    end else if (req.active_match_mask[b]) begin
                        log_event(b, EV_CANCEL, '0, '0);
                        emit_at[b] = '0;
                    end
                end
            end

            // hold repeat walk
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (!stable[b] || !cfg.repeat_mask[b]) continue;
                elapsed = now - emit_at[b];
                if (elapsed < {16'b0, cfg.repeat_interval_ms}) continue;
                log_event(b, EV_REPEAT, cfg.inject_hold_ms, '0);
                emit_at[b] = now;
            end

            foreach (sample_events[k]) begin
                ev = sample_events[k];
                ev.last_event = (k == sample_events.size() - 1);
                pending_events.push_back(ev);
                kind_seen[ev.event_kind]++;
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                n_errors++;
            end
        endfunction

        function void check_event(t_out got);
            t_out want;
            if (pending_events.size() == 0) begin
                $error("event with nothing pending: button %0d kind %0d",
                       got.button_index, got.event_kind);
                n_errors++;
                return;
            end
            want = pending_events.pop_front();
            n_checked++;
            check_field("button_index", 32'(want.button_index), 32'(got.button_index));
            check_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            check_field("hold_time_ms", 32'(want.hold_time_ms), 32'(got.hold_time_ms));
            check_field("press_len_ms", want.press_len_ms, got.press_len_ms);
            check_field("last_event", 32'(want.last_event), 32'(got.last_event));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    press_event_tracker tracker = new();

    multi_button_press_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("multi_button_press_classifier regression: fail");
        $finish;
    end

    // random output backpressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // both handshakes are observed at the edge where they complete
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) tracker.note_sample(i_in_data);
            if (o_out_valid && !i_out_stall) tracker.check_event(o_out_data);
        end
    end

    function automatic t_cfg make_cfg(logic [15:0] poll, logic [7:0] deb,
                                      logic [15:0] short_max, logic [15:0] medium_max,
                                      logic [NUM_BUTTONS-1:0] rel,
                                      logic [NUM_BUTTONS-1:0] rep,
                                      logic [15:0] ivl, logic [15:0] hold);
        t_cfg c;
        c.poll_interval_ms   = poll;
        c.debounce_ms        = deb;
        c.short_max_ms       = short_max;
        c.medium_max_ms      = medium_max;
        c.release_class_mask = rel;
        c.repeat_mask        = rep;
        c.repeat_interval_ms = ivl;
        c.inject_hold_ms     = hold;
        return c;
    endfunction

    // moderate settings; swap_limits puts the short limit at or above the medium one
    function automatic t_cfg random_cfg(bit swap_limits);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = 16'($urandom_range(40, 400));
        hi = lo + 16'($urandom_range(0, 900));
        return make_cfg(16'($urandom_range(1, 25)), 8'($urandom_range(0, 60)),
                        swap_limits ? hi : lo, swap_limits ? lo : hi,
                        NUM_BUTTONS'($urandom_range(0, 63)),
                        NUM_BUTTONS'($urandom_range(0, 63)),
                        16'($urandom_range(30, 200)), 16'($urandom));
    endfunction

    // write every register; narrow registers get junk in their unused upper bits
    task automatic program_regs(t_cfg c);
        logic [15:0] val [NUM_REGS];
        val[CFG_POLL_INTERVAL] = c.poll_interval_ms;
        val[CFG_DEBOUNCE]      = {8'($urandom), c.debounce_ms};
        val[CFG_SHORT_MAX]     = c.short_max_ms;
        val[CFG_MEDIUM_MAX]    = c.medium_max_ms;
        val[CFG_RELEASE_MASK]  = {(16 - NUM_BUTTONS)'($urandom), c.release_class_mask};
        val[CFG_REPEAT_MASK]   = {(16 - NUM_BUTTONS)'($urandom), c.repeat_mask};
        val[CFG_REPEAT_IVL]    = c.repeat_interval_ms;
        val[CFG_INJECT_HOLD]   = c.inject_hold_ms;
        for (int k = 0; k < NUM_REGS; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= val[k];
            tracker.write_reg(3'(k), val[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // one poll request, held until accepted
    task automatic send_request(logic [NUM_BUTTONS-1:0] raw, logic [31:0] at_ms,
                                logic [NUM_BUTTONS-1:0] active);
        t_in req;
        req.raw_levels        = raw;
        req.time_ms           = at_ms;
        req.active_match_mask = active;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drop valid and wait until all events are in and the walk has finished
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // held buttons with random content, some bounce, early samples and time jumps
    task automatic run_random(t_cfg c, int idle_pct, int stall_in);
        logic [31:0]            now_ms;
        logic [31:0]            gap_ms;
        logic [NUM_BUTTONS-1:0] held;
        logic [NUM_BUTTONS-1:0] raw;
        int                     target;
        int                     r;
        program_regs(c);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        now_ms = $urandom;
        held   = NUM_BUTTONS'($urandom_range(0, 63));
        target = tracker.n_samples + PHASE_SAMPLES;
        while (tracker.n_samples < target) begin
            r = $urandom_range(99);
            if (r < 8 && c.poll_interval_ms != 0)
                gap_ms = 32'($urandom_range(0, c.poll_interval_ms - 1));
            else if (r < 11)
                gap_ms = {16'b0, c.poll_interval_ms} + 32'($urandom_range(1, 5000));
            else if (r < 12)
                gap_ms = $urandom;
            else
                gap_ms = {16'b0, c.poll_interval_ms} + 32'($urandom_range(0, 30));
            now_ms = now_ms + gap_ms;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if ($urandom_range(99) < 12) held[b] = ~held[b];
            end
            raw = held;
            if ($urandom_range(99) < 10) raw[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
            send_request(raw, now_ms, NUM_BUTTONS'($urandom_range(0, 63)));
        end
        wait_idle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: bounce window, early sample, press, medium release, cancels
        send_request(6'h3F, 32'd100, 6'h3F);
        send_request(6'h3F, 32'd105, 6'h3F);
        send_request(6'h3F, 32'd130, 6'h3F);
        send_request(6'h00, 32'd700, 6'h3F);
        send_request(6'h00, 32'd720, 6'h2A);
        wait_idle();

        // no poll or debounce limit, repeat on every sample, press at time zero,
        // release across the time wrap
        program_regs(make_cfg(16'd0, 8'd0, 16'hFFFF, 16'd0, 6'h15, 6'h3F, 16'd0, 16'hFFFF));
        send_request(6'h3F, 32'd0, 6'h3F);
        send_request(6'h3F, 32'd0, 6'h00);
        send_request(6'h00, 32'hFFFF_FFFF, 6'h3F);
        send_request(6'h3F, 32'hFFFF_FFF0, 6'h00);
        send_request(6'h00, 32'h0000_0010, 6'h3F);
        wait_idle();

        // longest debounce, exact debounce edge, bounce rejected, short limit above medium
        program_regs(make_cfg(16'd1, 8'd255, 16'd400, 16'd300, 6'h3F, 6'h00,
                              16'hFFFF, 16'd0));
        send_request(6'h03, 32'd1000, 6'h00);
        send_request(6'h03, 32'd1254, 6'h00);
        send_request(6'h03, 32'd1255, 6'h00);
        send_request(6'h06, 32'd1300, 6'h00);
        send_request(6'h02, 32'd1400, 6'h00);
        send_request(6'h00, 32'd1450, 6'h00);
        send_request(6'h00, 32'd1555, 6'h00);
        send_request(6'h00, 32'd1705, 6'h00);
        wait_idle();

        run_random(random_cfg(1'b0), 0, 0);
        run_random(random_cfg(1'b1), 58, 0);
        run_random(make_cfg(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 6'h3F, 6'h3F,
                            16'hFFFF, 16'hFFFF), 0, 58);
        run_random(make_cfg(16'd0, 8'd0, 16'd0, 16'd0, 6'h00, 6'h3F, 16'd0, 16'd0), 20, 20);
        run_random(random_cfg(1'b0), 0, 0);

        $display("covered %0d polled samples (%0d early ones dropped), %0d events checked",
                 tracker.n_samples, tracker.n_skipped, tracker.n_checked);
        $display("events: press %0d short %0d medium %0d long %0d cancel %0d repeat %0d",
                 tracker.kind_seen[EV_PRESS], tracker.kind_seen[EV_SHORT],
                 tracker.kind_seen[EV_MEDIUM], tracker.kind_seen[EV_LONG],
                 tracker.kind_seen[EV_CANCEL], tracker.kind_seen[EV_REPEAT]);
        if (tracker.n_errors == 0 && tracker.pending_events.size() == 0)
            $display("multi_button_press_classifier regression: pass");
        else
            $display("multi_button_press_classifier regression: fail");
        $finish;
    end

endmodule
